// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg - shared types and constants of the segment frame receiver
// frame geometry, queue sizing and the command passed from front to back
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int SEGMENTS_PER_FRAME = 512;
  localparam int PINS_PER_CHIP      = 16;
  localparam int ROWS               = 4;
  localparam int CHIPS_PER_CHANNEL  = 4;
  localparam int SOUTH_OFFSET       = 4;

  localparam int CNT_W  = $clog2(SEGMENTS_PER_FRAME);
  localparam int ADDR_W = 9;

  localparam logic [15:0] ABORT_LIMIT = 16'hff00;
  localparam logic [15:0] ALL_ONES    = 16'hffff;
  localparam logic [7:0]  BYTE_FF     = 8'hff;
  localparam logic [7:0]  BYTE_F0     = 8'hf0;
  localparam logic [7:0]  BYTE_00     = 8'h00;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // one unit of work for the back part: a segment write or a frame end
  typedef struct packed {
    logic             write;
    logic             fend;
    logic             good;
    logic [CNT_W-1:0] idx;
    logic [7:0]       hi;
    logic [7:0]       lo;
  } cmd_t;

  // one finished result beat
  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        high_value;
    logic [7:0]        low_value;
    logic              frame_end;
    logic              frame_good;
  } res_t;

endpackage

// File: rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front - byte pairing, frame phase and trailer machine
// turns each accepted byte into at most one command for the back part
// ----------------------------------------------------------------------------
module sfr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          second_half,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output logic          cmd_valid,
  output sfr_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_SKIP  = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_TRAIL = 4'b1000
  } phase_t;

  typedef enum logic [9:0] {
    T_GOOD     = 10'b00_0000_0001,
    T_GOOD_00  = 10'b00_0000_0010,
    T_GOOD_X   = 10'b00_0000_0100,
    T_GOOD_FF  = 10'b00_0000_1000,
    T_GOOD_FF2 = 10'b00_0001_0000,
    T_GOOD_FF3 = 10'b00_0010_0000,
    T_BAD      = 10'b00_0100_0000,
    T_BAD_FF   = 10'b00_1000_0000,
    T_BAD_FF2  = 10'b01_0000_0000,
    T_BAD_FF3  = 10'b10_0000_0000
  } trail_t;

  phase_t                    phase_r, phase_nxt, ph;
  trail_t                    trail_r, trail_nxt, tnext;
  logic [7:0]                hold_r, hold_nxt;
  logic                      odd_r, odd_nxt;
  logic [sfr_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      t_end, t_good;
  logic [15:0]               value;
  logic                      is_ff, is_f0, is_00;
  logic                      last_value;

  assign is_ff      = (rx_byte == sfr_pkg::BYTE_FF);
  assign is_f0      = (rx_byte == sfr_pkg::BYTE_F0);
  assign is_00      = (rx_byte == sfr_pkg::BYTE_00);
  assign value      = {rx_byte, hold_r};
  assign last_value = (count_r == sfr_pkg::CNT_W'(sfr_pkg::SEGMENTS_PER_FRAME - 1));

  // phase seen by this byte: frame start resolves to skip or data
  always_comb begin
    if (phase_r == PH_START) begin
      ph = second_half ? PH_SKIP : PH_DATA;
    end else begin
      ph = phase_r;
    end
  end

  // trailer transition for FF FF FF F0
  always_comb begin
    tnext  = T_BAD;
    t_end  = 1'b0;
    t_good = 1'b0;
    unique case (trail_r)
      T_GOOD: begin
        if (is_00) tnext = T_GOOD_00;
        else if (is_ff) tnext = T_GOOD_FF;
        else tnext = T_GOOD_X;
      end
      T_GOOD_00:  tnext = T_GOOD;
      T_GOOD_X:   tnext = is_ff ? T_BAD_FF : T_GOOD;
      T_GOOD_FF:  tnext = is_ff ? T_GOOD_FF2 : T_GOOD;
      T_GOOD_FF2: tnext = is_ff ? T_GOOD_FF3 : T_BAD;
      T_GOOD_FF3: begin
        tnext  = is_ff ? T_BAD_FF3 : T_BAD;
        t_end  = is_f0;
        t_good = is_f0;
      end
      T_BAD:      tnext = is_ff ? T_BAD_FF : T_BAD;
      T_BAD_FF:   tnext = is_ff ? T_BAD_FF2 : T_BAD;
      T_BAD_FF2:  tnext = is_ff ? T_BAD_FF3 : T_BAD;
      T_BAD_FF3: begin
        tnext = is_ff ? T_BAD_FF3 : T_BAD;
        t_end = is_f0;
      end
      default:    tnext = T_BAD;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    trail_nxt = trail_r;
    hold_nxt  = hold_r;
    odd_nxt   = odd_r;
    count_nxt = count_r;
    cmd_valid = 1'b0;
    cmd       = '0;
    if (accept) begin
      phase_nxt = ph;
      if (ph == PH_TRAIL) begin
        if (t_end) begin
          cmd_valid = 1'b1;
          cmd.fend  = 1'b1;
          cmd.good  = t_good;
          phase_nxt = PH_START;
          trail_nxt = T_GOOD;
          count_nxt = '0;
          odd_nxt   = 1'b0;
          hold_nxt  = '0;
        end else begin
          trail_nxt = tnext;
        end
      end else if (!odd_r) begin
        hold_nxt = rx_byte;
        odd_nxt  = 1'b1;
      end else begin
        odd_nxt = 1'b0;
        if (value > sfr_pkg::ABORT_LIMIT) begin
          phase_nxt = PH_TRAIL;
          trail_nxt = (value == sfr_pkg::ALL_ONES) ? T_BAD_FF2 : T_BAD_FF;
          count_nxt = '0;
        end else if (ph == PH_SKIP) begin
          count_nxt = count_r + 1'b1;
          if (last_value) begin
            phase_nxt = PH_DATA;
            count_nxt = '0;
          end
        end else begin
          cmd_valid = 1'b1;
          cmd.write = 1'b1;
          cmd.idx   = count_r;
          cmd.hi    = rx_byte;
          cmd.lo    = hold_r;
          count_nxt = count_r + 1'b1;
          if (last_value) begin
            phase_nxt = PH_TRAIL;
            trail_nxt = T_GOOD;
            count_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      trail_r <= T_GOOD;
      hold_r  <= '0;
      odd_r   <= 1'b0;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      trail_r <= trail_nxt;
      hold_r  <= hold_nxt;
      odd_r   <= odd_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/sfr_cmd_queue.sv
// ----------------------------------------------------------------------------
// sfr_cmd_queue - short command queue between front and back
// lets each side stall on its own
// ----------------------------------------------------------------------------
module sfr_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output sfr_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  sfr_pkg::cmd_t              entries_r [sfr_pkg::QUEUE_DEPTH];
  logic [sfr_pkg::QPTR_W-1:0] wptr_r, rptr_r;
  logic [sfr_pkg::QPTR_W:0]   count_r;
  logic                       do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (sfr_pkg::QPTR_W + 1)'(sfr_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop) rptr_r <= rptr_r + 1'b1;
      count_r <= count_r + (sfr_pkg::QPTR_W + 1)'(do_push)
                         - (sfr_pkg::QPTR_W + 1)'(do_pop);
    end
  end

endmodule

// File: rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back - frame store address map and result buffer
// maps a segment index to its store address and holds two result beats
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  sfr_pkg::cmd_t q_head,
  output logic          q_pop,
  input  logic          res_pop,
  output logic          res_empty,
  output sfr_pkg::res_t res
);

  localparam int HALF        = sfr_pkg::SEGMENTS_PER_FRAME / 2;
  localparam int ROW_STRIDE  = sfr_pkg::SEGMENTS_PER_FRAME / sfr_pkg::ROWS;
  localparam int CHIP_STRIDE = sfr_pkg::PINS_PER_CHIP * 2;
  localparam int CHIP_SPAN   = sfr_pkg::PINS_PER_CHIP * sfr_pkg::ROWS;

  // segment order A B C D E F G1 G2 H J K L M N Dp nc -> driver pin
  function automatic logic [3:0] pin_of_seg(input logic [3:0] seg);
    logic [3:0] pin;
    unique case (seg)
      4'd0:    pin = 4'd12;
      4'd1:    pin = 4'd13;
      4'd2:    pin = 4'd1;
      4'd3:    pin = 4'd6;
      4'd4:    pin = 4'd0;
      4'd5:    pin = 4'd15;
      4'd6:    pin = 4'd11;
      4'd7:    pin = 4'd7;
      4'd8:    pin = 4'd14;
      4'd9:    pin = 4'd10;
      4'd10:   pin = 4'd9;
      4'd11:   pin = 4'd4;
      4'd12:   pin = 4'd3;
      4'd13:   pin = 4'd2;
      4'd14:   pin = 4'd5;
      default: pin = 4'd8;
    endcase
    return pin;
  endfunction

  function automatic logic [sfr_pkg::ADDR_W-1:0] store_address(
    input logic [sfr_pkg::CNT_W-1:0] idx
  );
    logic                      north;
    logic [sfr_pkg::CNT_W-1:0] rel;
    logic [31:0]               row, chip, pin, spot, base;
    north = (idx < sfr_pkg::CNT_W'(HALF));
    rel   = north ? idx : idx - sfr_pkg::CNT_W'(HALF);
    row   = 32'((rel / sfr_pkg::PINS_PER_CHIP) % sfr_pkg::ROWS);
    chip  = 32'(rel / CHIP_SPAN);
    pin   = 32'(pin_of_seg(4'(rel % sfr_pkg::PINS_PER_CHIP)));
    // pin interleave (p & ~3) + p
    spot  = (pin & ~32'd3) + pin;
    if (north) begin
      base = chip * CHIP_STRIDE;
    end else begin
      base = (32'(sfr_pkg::CHIPS_PER_CHANNEL - 1) - chip) * CHIP_STRIDE
             + 32'(sfr_pkg::SOUTH_OFFSET);
    end
    return sfr_pkg::ADDR_W'(base + row * ROW_STRIDE + spot);
  endfunction

  sfr_pkg::res_t slot0_r, slot1_r, fresh;
  logic [1:0]    count_r;
  logic          take, give;

  assign res_empty = (count_r == 2'd0);
  assign res       = slot0_r;
  assign give      = res_pop && !res_empty;
  assign take      = !q_empty && (count_r != 2'd2);
  assign q_pop     = take;

  always_comb begin
    fresh               = '0;
    fresh.write_valid   = q_head.write;
    fresh.write_address = q_head.write ? store_address(q_head.idx) : '0;
    fresh.high_value    = q_head.hi;
    fresh.low_value     = q_head.lo;
    fresh.frame_end     = q_head.fend;
    fresh.frame_good    = q_head.good;
  end

  always_ff @(posedge clk) begin
    if (take && (count_r == 2'd0 || (count_r == 2'd1 && give))) begin
      slot0_r <= fresh;
    end else if (give) begin
      slot0_r <= slot1_r;
    end
    if (take && count_r == 2'd1 && !give) begin
      slot1_r <= fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_r + 2'(take) - 2'(give);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer count out of range");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !res_empty |-> (res.write_valid ^ res.frame_end))
    else $error("result beat is neither a write nor a frame end");

  a_good_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!res_empty && res.frame_good) |-> res.frame_end)
    else $error("frame_good without frame_end");

  a_take_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !give) |=> (count_r == $past(count_r) + 2'd1))
    else $error("result buffer lost a beat");
`endif

endmodule

// File: rtl/segment_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// segment_frame_receiver_unit - serial byte to segment frame store receiver
// pairs bytes into 16-bit segment values, maps them to store addresses and
// checks the frame trailer
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+------------------------------
//   in       | input     | in_push/in_full   | in_rx_byte
//   out      | output    | out_empty/out_pop | out_write_valid,
//            |           |                   | out_write_address,
//            |           |                   | out_high_value, out_low_value,
//            |           |                   | out_frame_end, out_frame_good
//   cfg      | input     | cfg_we            | cfg_second_half
//
// one byte beat is taken every cycle while in_full is low
// a result reaches the out ports by way of a command queue entry and then a
//   result buffer slot; it waits in the queue while the result buffer is full
// in_full is the 4-entry command queue's full flag; the queue fills only while the
//   2-beat result buffer is full, so five or six results wait as out_pop was held
//   low; while it is high every byte is held off, also bytes that make no result
// synchronous active-low reset; no clearing pass, the block is ready at once
// ----------------------------------------------------------------------------
module segment_frame_receiver_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic                        cfg_second_half,
  // byte input
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [7:0]                  in_rx_byte,
  // result output
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_write_valid,
  output logic [sfr_pkg::ADDR_W-1:0]  out_write_address,
  output logic [7:0]                  out_high_value,
  output logic [7:0]                  out_low_value,
  output logic                        out_frame_end,
  output logic                        out_frame_good
);

  // second_half register, sampled by the front at each frame start
  logic          second_half_r;

  logic          in_accept;
  logic          cmd_valid;
  sfr_pkg::cmd_t cmd;
  sfr_pkg::cmd_t q_head;
  logic          q_empty, q_full, q_pop;
  sfr_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_half_r <= 1'b0;
    end else if (cfg_we) begin
      second_half_r <= cfg_second_half;
    end
  end

  // any byte may produce a command, so a full queue holds off every beat
  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  // front: pairing, phase and trailer tracking
  sfr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .second_half (second_half_r),
    .accept      (in_accept),
    .rx_byte     (in_rx_byte),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd)
  );

  // decoupling queue
  sfr_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_valid),
    .push_cmd (cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back: address map and result buffer
  sfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_pop   (out_pop),
    .res_empty (out_empty),
    .res       (res)
  );

  assign out_write_valid   = res.write_valid;
  assign out_write_address = res.write_address;
  assign out_high_value    = res.high_value;
  assign out_low_value     = res.low_value;
  assign out_frame_end     = res.frame_end;
  assign out_frame_good    = res.frame_good;

endmodule

// File: verif/sfr_frame_checker.sv
// ----------------------------------------------------------------------------
// sfr_frame_checker - result predictor and scoreboard for the frame receiver
// follows every accepted byte beat with its own model of the receiver, queues
// the store writes and frame ends it should cause and compares each popped
// result beat against the oldest one
// ----------------------------------------------------------------------------
module sfr_frame_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_second_half,
  input  logic                       in_push,
  input  logic                       in_full,
  input  logic [7:0]                 in_rx_byte,
  input  logic                       out_empty,
  input  logic                       out_pop,
  input  logic                       out_write_valid,
  input  logic [sfr_pkg::ADDR_W-1:0] out_write_address,
  input  logic [7:0]                 out_high_value,
  input  logic [7:0]                 out_low_value,
  input  logic                       out_frame_end,
  input  logic                       out_frame_good,
  output int                         fail_count,
  output int                         waiting_beats
);

  typedef enum logic [1:0] {SKIP_FRAME, KEEP_DATA, TRAILER, FRAME_START} rx_phase_t;

  typedef enum logic [3:0] {
    TR_GOOD, TR_GOOD_00, TR_GOOD_X, TR_GOOD_FF, TR_GOOD_FF2, TR_GOOD_FF3,
    TR_BAD, TR_BAD_FF, TR_BAD_FF2, TR_BAD_FF3, TR_END_GOOD, TR_END_BAD
  } trail_t;

  rx_phase_t     ph;
  trail_t        tr;
  logic          half_cfg;
  logic [7:0]    hold;
  logic          odd;
  int unsigned   vcount;
  sfr_pkg::res_t pending_beats[$];

  // segment index -> frame store address
  function automatic logic [sfr_pkg::ADDR_W-1:0] store_addr(input int unsigned idx);
    int unsigned half_n, row_stride, chip_stride, rel, seg, row, chip, pin, spot, base_a, sum;
    logic north;
    half_n      = sfr_pkg::SEGMENTS_PER_FRAME / 2;
    row_stride  = sfr_pkg::SEGMENTS_PER_FRAME / sfr_pkg::ROWS;
    chip_stride = sfr_pkg::PINS_PER_CHIP * 2;
    north = idx < half_n;
    rel   = north ? idx : idx - half_n;
    seg   = rel % sfr_pkg::PINS_PER_CHIP;
    row   = (rel / sfr_pkg::PINS_PER_CHIP) % sfr_pkg::ROWS;
    chip  = rel / (sfr_pkg::PINS_PER_CHIP * sfr_pkg::ROWS);
    // segment order to driver pin
    case (seg & 15)
      0:  pin = 12;
      1:  pin = 13;
      2:  pin = 1;
      3:  pin = 6;
      4:  pin = 0;
      5:  pin = 15;
      6:  pin = 11;
      7:  pin = 7;
      8:  pin = 14;
      9:  pin = 10;
      10: pin = 9;
      11: pin = 4;
      12: pin = 3;
      13: pin = 2;
      14: pin = 5;
      default: pin = 8;
    endcase
    spot = (pin & ~32'd3) + pin;
    if (north) begin
      base_a = chip * chip_stride;
    end else begin
      base_a = (sfr_pkg::CHIPS_PER_CHANNEL - 1 - chip) * chip_stride
               + sfr_pkg::SOUTH_OFFSET;
    end
    sum = base_a + row * row_stride + spot;
    return sum[sfr_pkg::ADDR_W-1:0];
  endfunction

  // trailer search, looking for ff ff ff f0
  function automatic trail_t trailer_step(input trail_t st, input logic [7:0] b);
    trail_t nx;
    nx = TR_BAD;
    case (st)
      TR_GOOD: begin
        if (b == sfr_pkg::BYTE_00) nx = TR_GOOD_00;
        else if (b == sfr_pkg::BYTE_FF) nx = TR_GOOD_FF;
        else nx = TR_GOOD_X;
      end
      TR_GOOD_00:  nx = TR_GOOD;
      TR_GOOD_X:   nx = (b == sfr_pkg::BYTE_FF) ? TR_BAD_FF : TR_GOOD;
      TR_GOOD_FF:  nx = (b == sfr_pkg::BYTE_FF) ? TR_GOOD_FF2 : TR_GOOD;
      TR_GOOD_FF2: nx = (b == sfr_pkg::BYTE_FF) ? TR_GOOD_FF3 : TR_BAD;
      TR_GOOD_FF3: begin
        if (b == sfr_pkg::BYTE_FF) nx = TR_BAD_FF3;
        else if (b == sfr_pkg::BYTE_F0) nx = TR_END_GOOD;
        else nx = TR_BAD;
      end
      TR_BAD:      nx = (b == sfr_pkg::BYTE_FF) ? TR_BAD_FF : TR_BAD;
      TR_BAD_FF:   nx = (b == sfr_pkg::BYTE_FF) ? TR_BAD_FF2 : TR_BAD;
      TR_BAD_FF2:  nx = (b == sfr_pkg::BYTE_FF) ? TR_BAD_FF3 : TR_BAD;
      TR_BAD_FF3: begin
        if (b == sfr_pkg::BYTE_FF) nx = TR_BAD_FF3;
        else if (b == sfr_pkg::BYTE_F0) nx = TR_END_BAD;
        else nx = TR_BAD;
      end
      default:     nx = TR_BAD;
    endcase
    return nx;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    sfr_pkg::res_t r;
    logic [15:0]   v;
    trail_t        nx;
    r = '0;
    if (ph == FRAME_START) ph = half_cfg ? SKIP_FRAME : KEEP_DATA;
    if (ph == TRAILER) begin
      nx = trailer_step(tr, b);
      if (nx == TR_END_GOOD || nx == TR_END_BAD) begin
        r.frame_end  = 1'b1;
        r.frame_good = (nx == TR_END_GOOD);
        pending_beats.push_back(r);
        ph     = FRAME_START;
        tr     = TR_GOOD;
        vcount = 0;
        odd    = 1'b0;
        hold   = '0;
      end else begin
        tr = nx;
      end
    end else if (!odd) begin
      hold = b;
      odd  = 1'b1;
    end else begin
      odd = 1'b0;
      v   = {b, hold};
      if (v > sfr_pkg::ABORT_LIMIT) begin
        ph     = TRAILER;
        tr     = (v == sfr_pkg::ALL_ONES) ? TR_BAD_FF2 : TR_BAD_FF;
        vcount = 0;
      end else if (ph == SKIP_FRAME) begin
        vcount++;
        if (vcount >= sfr_pkg::SEGMENTS_PER_FRAME) begin
          ph     = KEEP_DATA;
          vcount = 0;
        end
      end else begin
        r.write_valid   = 1'b1;
        r.write_address = store_addr(vcount);
        r.high_value    = b;
        r.low_value     = hold;
        pending_beats.push_back(r);
        vcount++;
        if (vcount >= sfr_pkg::SEGMENTS_PER_FRAME) begin
          ph     = TRAILER;
          tr     = TR_GOOD;
          vcount = 0;
        end
      end
    end
  endtask

  always @(posedge clk) begin : score
    sfr_pkg::res_t got, want;
    if (!rst_n) begin
      ph       = FRAME_START;
      tr       = TR_GOOD;
      half_cfg = 1'b0;
      hold     = '0;
      odd      = 1'b0;
      vcount   = 0;
      pending_beats.delete();
    end else begin
      if (cfg_we) half_cfg = cfg_second_half;
      if (out_pop && !out_empty) begin
        got.write_valid   = out_write_valid;
        got.write_address = out_write_address;
        got.high_value    = out_high_value;
        got.low_value     = out_low_value;
        got.frame_end     = out_frame_end;
        got.frame_good    = out_frame_good;
        if (pending_beats.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected beat wv=%0b addr=%0d hi=%02h lo=%02h end=%0b good=%0b",
                   $time, got.write_valid, got.write_address, got.high_value,
                   got.low_value, got.frame_end, got.frame_good);
        end else begin
          want = pending_beats.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: expected wv=%0b addr=%0d hi=%02h lo=%02h end=%0b good=%0b",
                     $time, want.write_valid, want.write_address, want.high_value,
                     want.low_value, want.frame_end, want.frame_good);
            $display("%0t: actual   wv=%0b addr=%0d hi=%02h lo=%02h end=%0b good=%0b",
                     $time, got.write_valid, got.write_address, got.high_value,
                     got.low_value, got.frame_end, got.frame_good);
          end
        end
      end
      if (in_push && !in_full) decode_byte(in_rx_byte);
    end
    waiting_beats <= pending_beats.size();
  end

endmodule

// File: verif/tb_segment_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// tb_segment_frame_receiver_unit - testbench of the segment frame receiver
// feeds byte beats shaped as frames (values, abort values, trailers) under
// both second_half settings, with random gaps on the byte side and random
// stalls on the result side; the checker beside the block predicts and
// scores every result beat
// ----------------------------------------------------------------------------
module tb_segment_frame_receiver_unit;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic                       cfg_second_half = 1'b0;
  logic                       in_push = 1'b0;
  logic                       in_full;
  logic [7:0]                 in_rx_byte = '0;
  logic                       out_empty;
  logic                       out_pop = 1'b0;
  logic                       out_write_valid;
  logic [sfr_pkg::ADDR_W-1:0] out_write_address;
  logic [7:0]                 out_high_value;
  logic [7:0]                 out_low_value;
  logic                       out_frame_end;
  logic                       out_frame_good;
  int                         fail_count;
  int                         waiting_beats;

  // calm = no gaps and no stalls on either side
  bit                         calm = 1'b0;
  int                         beats_sent = 0;
  int                         rand_stop;

  segment_frame_receiver_unit dut (.*);
  sfr_frame_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: out_pop is held low with a chance of 9 percent, never while calm
  always @(posedge clk) out_pop <= calm || ($urandom_range(0, 99) >= 9);

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // one byte beat; an optional one-cycle gap before it, then hold push until taken
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 9) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    beats_sent++;
  endtask

  // values go out low byte first
  task automatic send_value(input logic [15:0] v);
    send_byte(v[7:0]);
    send_byte(v[15:8]);
  endtask

  // a legal segment value, with the edges weighted up
  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return sfr_pkg::ABORT_LIMIT;
      default: return 16'($urandom_range(0, 16'hff00));
    endcase
  endfunction

  // a value above the limit, 0xffff about a third of the time
  function automatic logic [15:0] rand_abort();
    if ($urandom_range(0, 2) == 0) return sfr_pkg::ALL_ONES;
    return 16'($urandom_range(16'hff01, 16'hfffe));
  endfunction

  // n values, an optional abort value, then some trailer noise and ff ff ff f0
  task automatic send_frame(input int n_vals, input bit aborted);
    repeat (n_vals) send_value(rand_value());
    if (aborted) send_value(rand_abort());
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0:       send_byte(sfr_pkg::BYTE_00);
        1:       send_byte(sfr_pkg::BYTE_FF);
        2:       send_byte(sfr_pkg::BYTE_F0);
        default: send_byte(8'($urandom));
      endcase
    end
    repeat (3) send_byte(sfr_pkg::BYTE_FF);
    send_byte(sfr_pkg::BYTE_F0);
  endtask

  // stop sending, wait for every expected beat, then let the pipe settle
  task automatic drain();
    in_push <= 1'b0;
    do @(posedge clk); while (waiting_beats != 0);
    repeat (4) @(posedge clk);
  endtask

  // register write only once the block has gone quiet
  task automatic set_half(input bit h);
    drain();
    cfg_we          <= 1'b1;
    cfg_second_half <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: smallest value, the limit value itself, byte order check,
    // abort just above the limit, shortest bad trailer
    send_value(16'h0000);
    send_value(sfr_pkg::ABORT_LIMIT);
    send_value(16'h00ff);
    send_value(16'hff01);
    send_byte(sfr_pkg::BYTE_FF);
    send_byte(sfr_pkg::BYTE_FF);
    send_byte(sfr_pkg::BYTE_F0);
    // all-ones abort counts two ff bytes; a stray 00 knocks the trailer back
    send_value(16'h1234);
    send_value(sfr_pkg::ALL_ONES);
    send_byte(sfr_pkg::BYTE_00);
    repeat (3) send_byte(sfr_pkg::BYTE_FF);
    send_byte(sfr_pkg::BYTE_F0);

    // skip a whole frame, keep the next one; no gaps, no stalls
    set_half(1'b1);
    calm = 1'b1;
    send_frame(2 * sfr_pkg::SEGMENTS_PER_FRAME, 1'b0);
    calm = 1'b0;

    // one full frame kept straight away, walks every store address
    set_half(1'b0);
    send_frame(sfr_pkg::SEGMENTS_PER_FRAME, 1'b0);

    // skip done, then an abort in the kept part
    set_half(1'b1);
    send_frame(sfr_pkg::SEGMENTS_PER_FRAME + $urandom_range(1, 8), 1'b1);

    // register flip mid-frame: the frame keeps the setting it started with
    set_half(1'b0);
    repeat (5) send_value(rand_value());
    drain();
    set_half(1'b1);
    send_frame(3, 1'b1);

    // random frames, mostly short and aborted; some run on unaborted
    rand_stop = beats_sent + 750;
    while (beats_sent < rand_stop) begin
      if ($urandom_range(0, 9) == 0) set_half(1'($urandom_range(0, 1)));
      send_frame($urandom_range(0, 12), $urandom_range(0, 99) < 85);
    end

    drain();
    if (fail_count == 0 && waiting_beats == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
